// ===== design/sts_pkg.sv =====
// Shared types and constants for the sorted-table binary search block.
package sts_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned CNT_W  = 9;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_RESULT
  } st_state_t;

  typedef struct packed {
    logic write_entry;
    logic load_search;
    logic issue_probe;
    logic take_probe;
    logic set_miss;
    logic load_out;
  } sts_cmd_t;

  typedef struct packed {
    logic bounds_empty;
    logic probe_hit;
  } sts_status_t;

endpackage

// ===== design/sts_datapath.sv =====
// Datapath: table memory, search bounds, probe compare and result registers.
module sts_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sts_pkg::sts_cmd_t                    cmd,
  output sts_pkg::sts_status_t                 status,
  input  logic                                 cfg_valid,
  input  logic [sts_pkg::CNT_W-1:0]            cfg_data,
  input  logic [sts_pkg::SLOT_W-1:0]           in_slot,
  input  logic signed [sts_pkg::VAL_W-1:0]     in_value,
  output logic                                 out_found,
  output logic [sts_pkg::SLOT_W-1:0]           out_position
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_MAX = (1 << sts_pkg::CNT_W) - 1;
  localparam int CAP = (TABLE_DEPTH < CNT_MAX) ? TABLE_DEPTH : CNT_MAX;

  logic [sts_pkg::VAL_W-1:0]        mem [TABLE_DEPTH];
  logic [sts_pkg::VAL_W-1:0]        rd_data_r;
  logic [sts_pkg::CNT_W-1:0]        entries_r;
  logic [sts_pkg::CNT_W-1:0]        lo_r, lo_nxt;
  logic [sts_pkg::CNT_W-1:0]        hi_r, hi_nxt;
  logic [sts_pkg::CNT_W-1:0]        mid_r;
  logic [sts_pkg::CNT_W-1:0]        mid;
  logic [sts_pkg::CNT_W-1:0]        span;
  logic [sts_pkg::CNT_W-1:0]        limit;
  logic signed [sts_pkg::VAL_W-1:0] target_r;
  logic signed [sts_pkg::VAL_W-1:0] probe;
  logic                             res_found_r;
  logic [sts_pkg::SLOT_W-1:0]       res_pos_r;
  logic                             out_found_r;
  logic [sts_pkg::SLOT_W-1:0]       out_position_r;
  logic                             slot_ok;
  logic                             probe_lt;

  assign span  = hi_r - lo_r - sts_pkg::CNT_W'(1);
  assign mid   = lo_r + (span >> 1);
  assign limit = (entries_r > sts_pkg::CNT_W'(CAP)) ? sts_pkg::CNT_W'(CAP) : entries_r;
  assign slot_ok = (32'(in_slot) < 32'(TABLE_DEPTH));
  assign probe    = $signed(rd_data_r);
  assign probe_lt = (probe < target_r);

  assign status.bounds_empty = (lo_r >= hi_r);
  assign status.probe_hit    = (probe == target_r);

  // Bounds: reset per search, step past smaller probe, else narrow from above.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load_search) begin
      lo_nxt = '0;
      hi_nxt = limit;
    end else if (cmd.take_probe && !status.probe_hit) begin
      if (probe_lt) begin
        lo_nxt = mid_r + sts_pkg::CNT_W'(1);
      end else begin
        hi_nxt = mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
      lo_r      <= '0;
      hi_r      <= '0;
    end else begin
      if (cfg_valid) begin
        entries_r <= cfg_data;
      end
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry && slot_ok) begin
      mem[AW'(in_slot)] <= in_value;
    end
    if (cmd.issue_probe) begin
      rd_data_r <= mem[AW'(mid)];
      mid_r     <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      target_r <= in_value;
    end
    if (cmd.set_miss) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end else if (cmd.take_probe && status.probe_hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= mid_r[sts_pkg::SLOT_W-1:0];
    end
    if (cmd.load_out) begin
      out_found_r    <= res_found_r;
      out_position_r <= res_pos_r;
    end
  end

  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

// ===== design/sts_ctrl.sv =====
// Controller: sequences item intake, probe read/compare steps and result hand-off.
module sts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sts_pkg::sts_status_t status,
  output sts_pkg::sts_cmd_t    cmd
);

  sts_pkg::st_state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sts_pkg::ST_IDLE: begin
        if (in_valid && in_kind == sts_pkg::KIND_SEARCH) begin
          state_nxt = sts_pkg::ST_PROBE;
        end
      end
      sts_pkg::ST_PROBE: begin
        state_nxt = status.bounds_empty ? sts_pkg::ST_RESULT : sts_pkg::ST_CMP;
      end
      sts_pkg::ST_CMP: begin
        state_nxt = status.probe_hit ? sts_pkg::ST_RESULT : sts_pkg::ST_PROBE;
      end
      sts_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = sts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sts_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.write_entry = in_valid && in_kind == sts_pkg::KIND_WRITE;
        cmd.load_search = in_valid && in_kind == sts_pkg::KIND_SEARCH;
      end
      sts_pkg::ST_PROBE: begin
        cmd.issue_probe = !status.bounds_empty;
        cmd.set_miss    = status.bounds_empty;
      end
      sts_pkg::ST_CMP: begin
        cmd.take_probe = 1'b1;
      end
      sts_pkg::ST_RESULT: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Hold the result until taken; a fresh load wins over a take.
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sts_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sts_pkg::ST_CMP |-> $past(state_r) == sts_pkg::ST_PROBE)
    else $error("compare step without a preceding probe read");

  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == sts_pkg::KIND_SEARCH) |=> state_r == sts_pkg::ST_PROBE)
    else $error("accepted search item did not start probing");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sts_pkg::ST_PROBE && status.bounds_empty) |=> state_r == sts_pkg::ST_RESULT)
    else $error("empty bounds did not end the search");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sts_pkg::ST_RESULT && out_free) |=> (out_valid_r && state_r == sts_pkg::ST_IDLE))
    else $error("finished search did not present its result");
`endif

endmodule

// ===== design/sorted_table_binary_search.sv =====
// Top level of the sorted-table binary search block.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_kind, in_slot, in_value
//   out     | output    | out_valid / out_ready| out_found, out_position
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (entries_in_use)
//
// A write item is stored as it is accepted, and the block stays idle. After a search
// item is accepted, the block runs p probes, p being at most 9 for 256 entries; a
// match then goes to the result step, while a miss ends at an empty-bounds check.
// Each probe is a registered memory read followed by a compare and bound update.
// Reset (rst_n low, synchronous) clears control state and entries_in_use; table
// contents are undefined until written. A waiting result holds in the output
// register, and write items are still taken while it waits.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [sts_pkg::SLOT_W-1:0]       in_slot,
  input  logic signed [sts_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [sts_pkg::SLOT_W-1:0]       out_position,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sts_pkg::CNT_W-1:0]        cfg_data
);

  sts_pkg::sts_cmd_t    cmd;
  sts_pkg::sts_status_t status;

  assign cfg_ready = 1'b1;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_slot      (in_slot),
    .in_value     (in_value),
    .out_found    (out_found),
    .out_position (out_position)
  );

endmodule
